// ===== hw/rtl/nnt_pkg.sv =====
// ----------------------------------------------------------------------------
// nnt_pkg
// Shared widths, codes and sequencer states of the nearest-neighbour tour.
// ----------------------------------------------------------------------------
package nnt_pkg;

	localparam int unsigned MAX_NODES  = 16;
	localparam int unsigned NODE_W     = $clog2(MAX_NODES);
	localparam int unsigned DIST_W     = 20;
	localparam int unsigned PAIR_DEPTH = MAX_NODES * MAX_NODES;
	localparam int unsigned PAIR_AW    = $clog2(PAIR_DEPTH);

	localparam logic [DIST_W-1:0] LEG_LIMIT_RST = DIST_W'(99900);

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [DIST_W-1:0] dist_t;

	typedef enum logic [1:0] {
		OP_PAIR   = 2'd0,
		OP_ORIGIN = 2'd1,
		OP_MEMBER = 2'd2,
		OP_RUN    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ASCAN,
		ST_SEED,
		ST_STEP,
		ST_EMIT,
		ST_NOSTART
	} state_t;

endpackage

// ===== hw/rtl/nnt_ifs.sv =====
// ----------------------------------------------------------------------------
// nnt_ifs
// Valid/ready channels of the tour block: request, result and configuration.
// ----------------------------------------------------------------------------
interface nnt_req_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 op;
	logic [nnt_pkg::NODE_W-1:0] from_node;
	logic [nnt_pkg::NODE_W-1:0] to_node;
	logic [nnt_pkg::DIST_W-1:0] distance;
	logic                       member;
	logic                       start_given;

	modport source (output valid, op, from_node, to_node, distance, member, start_given,
		input ready);
	modport sink (input valid, op, from_node, to_node, distance, member, start_given,
		output ready);
endinterface

interface nnt_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [nnt_pkg::NODE_W-1:0] node;
	logic [nnt_pkg::DIST_W-1:0] leg_distance;
	logic                       last;
	logic                       no_start;

	modport source (output valid, node, leg_distance, last, no_start, input ready);
	modport sink (input valid, node, leg_distance, last, no_start, output ready);
endinterface

interface nnt_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [nnt_pkg::DIST_W-1:0] leg_limit;

	modport source (output valid, leg_limit, input ready);
	modport sink (input valid, leg_limit, output ready);
endinterface

// ===== hw/rtl/nnt_ram.sv =====
// ----------------------------------------------------------------------------
// nnt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nnt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/nearest_neighbor_tour.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_tour
// Greedy nearest-neighbour tour over a loaded directed distance store.
//
//   port  role    carries
//   ----  ------  ----------------------------------------------------------
//   req   sink    op, from_node, to_node, distance, member, start_given
//   rsp   source  node, leg_distance, last, no_start
//   cfg   sink    leg_limit (always ready)
//
// Loads are taken only while idle. A run without a given start first scans
// the origin distances for an automatic start, then each tour step scans one
// row of the pair RAM through its single read port.
// After reset a pass zeroes the pair RAM; req.ready stays low meanwhile.
// A stalled rsp holds the sequencer in its emit state.
// ----------------------------------------------------------------------------
module nearest_neighbor_tour (
	input  logic          clk,
	input  logic          arst_n,
	nnt_req_if.sink       req,
	nnt_rsp_if.source     rsp,
	nnt_cfg_if.sink       cfg
);

	localparam int unsigned N  = nnt_pkg::MAX_NODES;
	localparam int unsigned NW = nnt_pkg::NODE_W;
	localparam int unsigned DW = nnt_pkg::DIST_W;
	localparam int unsigned AW = nnt_pkg::PAIR_AW;

	nnt_pkg::state_t state_q, state_d;

	logic [AW-1:0]      clr_q;
	logic [NW:0]        scan_q;
	logic [NW-1:0]      idx_s1;
	logic               vld_s1;
	nnt_pkg::node_t     cur_q, best_node_q, pend_node_q;
	nnt_pkg::dist_t     best_q, pend_dist_q, leg_limit_q;
	logic               have_q;
	logic [N-1:0]       visited_q, member_q;
	nnt_pkg::dist_t     origin_q [N];
	logic               out_valid_q;
	nnt_pkg::node_t     out_node_q;
	nnt_pkg::dist_t     out_dist_q;
	logic               out_last_q, out_nostart_q;

	logic               req_take, run_take, slot_free;
	nnt_pkg::op_t       req_op;
	logic               ram_we, issue, out_load;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	nnt_pkg::dist_t     ram_wdata, rd_data;
	nnt_pkg::dist_t     cmp_a;
	logic [NW-1:0]      cmp_idx;
	logic               cmp_valid, cand_ok, take, scan_last, step_last;
	nnt_pkg::node_t     load_node;
	nnt_pkg::dist_t     load_dist;
	logic               load_last, load_nostart;

	assign req_op    = nnt_pkg::op_t'(req.op);
	assign req_take  = req.valid && req.ready;
	assign run_take  = req_take && (req_op == nnt_pkg::OP_RUN);
	assign slot_free = !out_valid_q || rsp.ready;
	assign cfg.ready = 1'b1;

	nnt_ram #(
		.WIDTH (DW),
		.DEPTH (nnt_pkg::PAIR_DEPTH)
	) u_pair_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	// shared compare unit: origin scan or pair row scan
	always_comb begin
		if (state_q == nnt_pkg::ST_ASCAN) begin
			cmp_a     = origin_q[scan_q[NW-1:0]];
			cmp_idx   = scan_q[NW-1:0];
			cmp_valid = 1'b1;
			cand_ok   = member_q[cmp_idx];
		end else begin
			cmp_a     = rd_data;
			cmp_idx   = idx_s1;
			cmp_valid = (state_q == nnt_pkg::ST_STEP) && vld_s1;
			cand_ok   = member_q[cmp_idx] && !visited_q[cmp_idx] && (cmp_a != '0)
				&& (cmp_a < leg_limit_q);
		end
		take = cmp_valid && cand_ok && (!have_q || (cmp_a < best_q));
	end

	assign scan_last = scan_q[NW-1:0] == NW'(N - 1);
	assign step_last = vld_s1 && (idx_s1 == NW'(N - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nnt_pkg::ST_CLEAR: begin
				if (clr_q == '1) state_d = nnt_pkg::ST_IDLE;
			end
			nnt_pkg::ST_IDLE: begin
				if (run_take) state_d = req.start_given ? nnt_pkg::ST_SEED : nnt_pkg::ST_ASCAN;
			end
			nnt_pkg::ST_ASCAN: begin
				if (scan_last) state_d = (have_q || take) ? nnt_pkg::ST_SEED : nnt_pkg::ST_NOSTART;
			end
			nnt_pkg::ST_SEED: begin
				state_d = nnt_pkg::ST_STEP;
			end
			nnt_pkg::ST_STEP: begin
				if (step_last) state_d = nnt_pkg::ST_EMIT;
			end
			nnt_pkg::ST_EMIT: begin
				if (slot_free) state_d = have_q ? nnt_pkg::ST_STEP : nnt_pkg::ST_IDLE;
			end
			nnt_pkg::ST_NOSTART: begin
				if (slot_free) state_d = nnt_pkg::ST_IDLE;
			end
			default: state_d = nnt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready    = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = {req.from_node, req.to_node};
		ram_wdata    = req.distance;
		ram_raddr    = {cur_q, scan_q[NW-1:0]};
		issue        = 1'b0;
		out_load     = 1'b0;
		load_node    = '0;
		load_dist    = '0;
		load_last    = 1'b0;
		load_nostart = 1'b0;
		unique case (state_q)
			nnt_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			nnt_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				ram_we    = req.valid && (req_op == nnt_pkg::OP_PAIR);
			end
			nnt_pkg::ST_STEP: begin
				issue = scan_q < (NW+1)'(N);
			end
			nnt_pkg::ST_EMIT: begin
				out_load  = slot_free;
				load_node = pend_node_q;
				load_dist = pend_dist_q;
				load_last = !have_q;
			end
			nnt_pkg::ST_NOSTART: begin
				out_load     = slot_free;
				load_nostart = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nnt_pkg::ST_CLEAR;
			clr_q       <= '0;
			leg_limit_q <= nnt_pkg::LEG_LIMIT_RST;
			member_q    <= '0;
			visited_q   <= '0;
			cur_q       <= '0;
			have_q      <= 1'b0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < N; i++) origin_q[i] <= '0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			if (cfg.valid) leg_limit_q <= cfg.leg_limit;
			if (state_q == nnt_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (req_take && (req_op == nnt_pkg::OP_ORIGIN)) origin_q[req.from_node] <= req.distance;
			if (req_take && (req_op == nnt_pkg::OP_MEMBER)) member_q[req.from_node] <= req.member;
			if (run_take) have_q <= 1'b0;
			if (take) have_q <= 1'b1;
			if (state_q == nnt_pkg::ST_SEED) begin
				visited_q <= N'(1) << best_node_q;
				cur_q     <= best_node_q;
				have_q    <= 1'b0;
			end
			if ((state_q == nnt_pkg::ST_EMIT) && slot_free && have_q) begin
				visited_q <= visited_q | (N'(1) << best_node_q);
				cur_q     <= best_node_q;
				have_q    <= 1'b0;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (run_take) begin
			scan_q      <= '0;
			best_node_q <= req.from_node;
		end
		if (state_q == nnt_pkg::ST_ASCAN) scan_q <= scan_q + (NW+1)'(1);
		if (issue) scan_q <= scan_q + (NW+1)'(1);
		idx_s1 <= scan_q[NW-1:0];
		if (take) begin
			best_q      <= cmp_a;
			best_node_q <= cmp_idx;
		end
		if (state_q == nnt_pkg::ST_SEED) begin
			pend_node_q <= best_node_q;
			pend_dist_q <= origin_q[best_node_q];
			scan_q      <= '0;
		end
		if ((state_q == nnt_pkg::ST_EMIT) && slot_free && have_q) begin
			pend_node_q <= best_node_q;
			pend_dist_q <= best_q;
			scan_q      <= '0;
		end
		if (out_load) begin
			out_node_q    <= load_node;
			out_dist_q    <= load_dist;
			out_last_q    <= load_last;
			out_nostart_q <= load_nostart;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.node         = out_node_q;
	assign rsp.leg_distance = out_dist_q;
	assign rsp.last         = out_last_q;
	assign rsp.no_start     = out_nostart_q;

	a_nostart_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.no_start |-> rsp.node == '0 && rsp.leg_distance == '0 && !rsp.last)
		else $error("no_start item carries nonzero fields");

	a_cur_visited: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == nnt_pkg::ST_STEP |-> visited_q[cur_q])
		else $error("current node not marked visited during step scan");

	a_busy_mid_tour: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.last && !rsp.no_start |-> !req.ready)
		else $error("request taken while tour still open");

endmodule
